/* src/integer_to_ascii_formatter_assert.svh */
// Assertion macros shared by the formatter's checker.
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH

// Whenever ante holds, cons must hold in the same cycle.
`define ITFMT_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Whenever ante holds, cons must hold in the next cycle.
`define ITFMT_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/itfmt_pkg.sv */
// Shared types, constants and helper functions for the integer formatter.
package itfmt_pkg;

  // digit store geometry: 22 octal digits cover 64 bits
  localparam int NUM_SLOTS = 22;
  localparam logic [4:0] DEC_DIGITS = 5'd20;
  localparam logic [4:0] OCT_DIGITS = 5'd22;
  localparam logic [4:0] HEX_DIGITS = 5'd16;
  localparam logic [5:0] LAST_BIT   = 6'd63;

  // base codes; code three is treated as hex
  localparam logic [1:0] BASE_DEC     = 2'd0;
  localparam logic [1:0] BASE_OCT     = 2'd1;
  localparam logic [1:0] BASE_HEX     = 2'd2;
  localparam logic [1:0] BASE_HEX_ALT = 2'd3;

  // format flag masks
  localparam logic [2:0] ZERO_FILL  = 3'd1;
  localparam logic [2:0] LEFT_ALIGN = 3'd2;
  localparam logic [2:0] PREFIX     = 3'd4;

  // ASCII codes
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_X_LO  = 8'h78;
  localparam logic [7:0] CH_X_UP  = 8'h58;
  localparam logic [7:0] CH_A_LO  = 8'h61;
  localparam logic [7:0] CH_A_UP  = 8'h41;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  base_select;
    logic        is_signed;
    logic        upper_case;
    logic [5:0]  min_width;
    logic [2:0]  format_flags;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last_char;
  } out_item_t;

  typedef struct packed {
    logic       done;
    logic [4:0] ndig;
  } dig_status_t;

  typedef enum logic [1:0] {
    DG_IDLE,
    DG_DABBLE,
    DG_NORM,
    DG_READY
  } dig_state_t;

  typedef enum logic [2:0] {
    EM_IDLE,
    EM_WAIT,
    EM_SIZE,
    EM_LEAD,
    EM_LPAD,
    EM_TEXT,
    EM_DIG,
    EM_RPAD
  } emit_state_t;

  typedef enum logic [1:0] {
    AFX_NONE,
    AFX_MINUS,
    AFX_OCT,
    AFX_HEX
  } affix_t;

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic up);
    logic [7:0] base_ch;
    base_ch = up ? CH_A_UP : CH_A_LO;
    if (d < 4'd10) begin
      return CH_ZERO + {4'd0, d};
    end
    return base_ch + {4'd0, d - 4'd10};
  endfunction

  function automatic logic [7:0] affix_char(input affix_t k, input logic pos, input logic up);
    logic [7:0] ch;
    case (k)
      AFX_MINUS: ch = CH_MINUS;
      AFX_HEX:   ch = pos ? (up ? CH_X_UP : CH_X_LO) : CH_ZERO;
      default:   ch = CH_ZERO;
    endcase
    return ch;
  endfunction

  function automatic logic [1:0] affix_len(input affix_t k);
    logic [1:0] n;
    case (k)
      AFX_MINUS: n = 2'd1;
      AFX_OCT:   n = 2'd1;
      AFX_HEX:   n = 2'd2;
      default:   n = 2'd0;
    endcase
    return n;
  endfunction

endpackage

/* src/itfmt_digits.sv */
// Digit unit: bit-serial binary-to-BCD for decimal, direct split for octal/hex, leading-zero skip.
module itfmt_digits (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   go,
  input  logic [63:0]            value,
  input  logic [1:0]             base_select,
  input  logic                   neg,
  input  logic                   pop,
  output itfmt_pkg::dig_status_t status,
  output logic [3:0]             digit
);
  import itfmt_pkg::*;

  dig_state_t state, state_next;
  logic [3:0]  digs [NUM_SLOTS];
  logic [3:0]  shifted [NUM_SLOTS];
  logic [3:0]  adj [NUM_SLOTS];
  logic [63:0] bin;
  logic [5:0]  bitcnt;
  logic [4:0]  ndig;
  logic [4:0]  top_idx;
  logic [63:0] mag;

  // magnitude of a signed decimal negative
  assign mag = neg ? (64'd0 - value) : value;

  // current most significant digit
  assign top_idx = ndig - 5'd1;
  assign digit   = digs[top_idx];

  // one double-dabble step: add 3 to digits of 5 and up, then shift in one bit
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      adj[i] = (digs[i] >= 4'd5) ? (digs[i] + 4'd3) : digs[i];
    end
    shifted[0] = {adj[0][2:0], bin[63]};
    for (int i = 1; i < NUM_SLOTS; i++) begin
      shifted[i] = {adj[i][2:0], adj[i-1][3]};
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      DG_IDLE: begin
        if (go) begin
          state_next = (base_select == BASE_DEC) ? DG_DABBLE : DG_NORM;
        end
      end
      DG_DABBLE: begin
        if (bitcnt == 6'd0) begin
          state_next = DG_NORM;
        end
      end
      DG_NORM: begin
        if (!(digit == 4'd0 && ndig != 5'd1)) begin
          state_next = DG_READY;
        end
      end
      DG_READY: begin
        if (pop && ndig == 5'd1) begin
          state_next = DG_IDLE;
        end
      end
      default: state_next = DG_IDLE;
    endcase
  end

  // status outputs
  always_comb begin
    status.done = (state == DG_READY);
    status.ndig = ndig;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= DG_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // digit store, binary shift register and counters
  always_ff @(posedge clk) begin
    case (state)
      DG_IDLE: begin
        if (go) begin
          bin    <= mag;
          bitcnt <= LAST_BIT;
          if (base_select == BASE_DEC) begin
            ndig <= DEC_DIGITS;
            for (int i = 0; i < NUM_SLOTS; i++) begin
              digs[i] <= 4'd0;
            end
          end else if (base_select == BASE_OCT) begin
            ndig <= OCT_DIGITS;
            for (int i = 0; i < NUM_SLOTS - 1; i++) begin
              digs[i] <= {1'b0, mag[3*i +: 3]};
            end
            digs[NUM_SLOTS-1] <= {3'd0, mag[63]};
          end else begin
            ndig <= HEX_DIGITS;
            for (int i = 0; i < NUM_SLOTS; i++) begin
              digs[i] <= (i < 16) ? mag[(4*i) % 64 +: 4] : 4'd0;
            end
          end
        end
      end
      DG_DABBLE: begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
          digs[i] <= shifted[i];
        end
        bin    <= {bin[62:0], 1'b0};
        bitcnt <= bitcnt - 6'd1;
      end
      DG_NORM: begin
        if (digit == 4'd0 && ndig != 5'd1) begin
          ndig <= ndig - 5'd1;
        end
      end
      DG_READY: begin
        if (pop) begin
          ndig <= ndig - 5'd1;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* src/itfmt_emit.sv */
// Character sequencer: sign/prefix, padding, digits, one character per cycle.
module itfmt_emit (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   go,
  input  itfmt_pkg::in_item_t    item,
  input  logic [5:0]             width,
  input  logic                   neg,
  input  itfmt_pkg::dig_status_t dstat,
  input  logic [3:0]             digit,
  output logic                   pop,
  output logic                   busy,
  output logic                   strobe,
  output itfmt_pkg::out_item_t   result
);
  import itfmt_pkg::*;

  emit_state_t state, state_next;
  emit_state_t after_lead, after_lpad;
  affix_t      affix;
  logic        upper, right, zpad, apos;
  logic [5:0]  effw, padcnt, pad_calc, len;
  logic [1:0]  alen;
  logic        has_afx, has_pad, afx_end;
  logic        go_right, go_zpad, go_pfx;
  logic        emit, last;
  logic [7:0]  ch, padc;

  // decode of the accepted beat
  assign go_right = |(item.format_flags & LEFT_ALIGN);
  assign go_zpad  = (width != 6'd0) && |(item.format_flags & ZERO_FILL) && !go_right;
  assign go_pfx   = |(item.format_flags & PREFIX) && |item.value
                    && (item.base_select != BASE_DEC);

  // sizing: affix counts toward text length only when it is not led out
  assign alen     = affix_len(affix);
  assign has_afx  = (alen != 2'd0);
  assign len      = {1'b0, dstat.ndig} + (zpad ? 6'd0 : {4'd0, alen});
  assign pad_calc = (effw > len) ? (effw - len) : 6'd0;
  assign has_pad  = (state == EM_SIZE) ? (pad_calc != 6'd0) : (padcnt != 6'd0);
  assign afx_end  = ((apos ? 2'd2 : 2'd1) == alen);
  assign padc     = zpad ? CH_ZERO : CH_SPACE;
  assign busy     = (state != EM_IDLE);

  // what follows the leading affix and the left padding
  always_comb begin
    if (!right && has_pad) begin
      after_lead = EM_LPAD;
    end else if (!zpad && has_afx) begin
      after_lead = EM_TEXT;
    end else begin
      after_lead = EM_DIG;
    end
    after_lpad = (!zpad && has_afx) ? EM_TEXT : EM_DIG;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      EM_IDLE: begin
        if (go) state_next = EM_WAIT;
      end
      EM_WAIT: begin
        if (dstat.done) state_next = EM_SIZE;
      end
      EM_SIZE: begin
        state_next = (zpad && has_afx) ? EM_LEAD : after_lead;
      end
      EM_LEAD: begin
        if (afx_end) state_next = after_lead;
      end
      EM_LPAD: begin
        if (padcnt == 6'd1) state_next = after_lpad;
      end
      EM_TEXT: begin
        if (afx_end) state_next = EM_DIG;
      end
      EM_DIG: begin
        if (dstat.ndig == 5'd1) state_next = (right && has_pad) ? EM_RPAD : EM_IDLE;
      end
      EM_RPAD: begin
        if (padcnt == 6'd1) state_next = EM_IDLE;
      end
      default: state_next = EM_IDLE;
    endcase
  end

  // character selection
  always_comb begin
    emit = 1'b0;
    last = 1'b0;
    pop  = 1'b0;
    ch   = CH_SPACE;
    case (state)
      EM_LEAD, EM_TEXT: begin
        emit = 1'b1;
        ch   = affix_char(affix, apos, upper);
      end
      EM_LPAD: begin
        emit = 1'b1;
        ch   = padc;
      end
      EM_DIG: begin
        emit = 1'b1;
        pop  = 1'b1;
        ch   = digit_char(digit, upper);
        last = (dstat.ndig == 5'd1) && !(right && has_pad);
      end
      EM_RPAD: begin
        emit = 1'b1;
        ch   = padc;
        last = (padcnt == 6'd1);
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= EM_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= emit;
    end
  end

  // per-number settings, counters and output beat
  always_ff @(posedge clk) begin
    result.char_out  <= ch;
    result.last_char <= last;
    case (state)
      EM_IDLE: begin
        if (go) begin
          upper <= item.upper_case;
          right <= go_right;
          zpad  <= go_zpad;
          effw  <= width - {5'd0, neg && go_zpad};
          if (neg) begin
            affix <= AFX_MINUS;
          end else if (go_pfx) begin
            affix <= (item.base_select == BASE_OCT) ? AFX_OCT : AFX_HEX;
          end else begin
            affix <= AFX_NONE;
          end
        end
      end
      EM_SIZE: begin
        padcnt <= pad_calc;
        apos   <= 1'b0;
      end
      EM_LEAD, EM_TEXT: begin
        apos <= !afx_end;
      end
      EM_LPAD, EM_RPAD: begin
        padcnt <= padcnt - 6'd1;
      end
      default: begin
      end
    endcase
  end

endmodule

/* src/integer_to_ascii_formatter.sv */
// Top level of the printf-style integer to ASCII formatter.
// A number is taken when start is high and busy is low; busy then stays high
// until the final character has been sent. Characters leave most significant
// first, one per cycle, each marked by strobe for exactly one cycle, with
// last_char set on the final one; the receiver cannot stall them. A decimal
// number passes through the bit-serial binary-to-BCD shifter, then drops
// leading zeros one per cycle (up to 19) and finds the top digit, then takes a
// handoff step and a sizing step before its characters. Octal and hex load at
// the accepting edge and drop up to 21 or 15 leading zeros, one per cycle,
// before the same handoff and sizing steps. Each character is registered and
// shows on the ports in the cycle after it is chosen. A new number may be
// started in the cycle that shows the last character.
module integer_to_ascii_formatter #(
  parameter int MAX_WIDTH = 62
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  output logic                 busy,
  input  itfmt_pkg::in_item_t  item,
  output logic                 strobe,
  output itfmt_pkg::out_item_t result
);
  import itfmt_pkg::*;

  localparam logic [5:0] MaxW = 6'(MAX_WIDTH);

  logic        go, neg, pop;
  logic [5:0]  width;
  logic [3:0]  digit;
  dig_status_t dstat;

  // accept, width clamp and sign detect
  assign go    = start && !busy;
  assign width = (item.min_width > MaxW) ? MaxW : item.min_width;
  assign neg   = item.is_signed && (item.base_select == BASE_DEC) && item.value[63];

  itfmt_digits u_digits (
    .clk         (clk),
    .rst         (rst),
    .go          (go),
    .value       (item.value),
    .base_select (item.base_select),
    .neg         (neg),
    .pop         (pop),
    .status      (dstat),
    .digit       (digit)
  );

  itfmt_emit u_emit (
    .clk    (clk),
    .rst    (rst),
    .go     (go),
    .item   (item),
    .width  (width),
    .neg    (neg),
    .dstat  (dstat),
    .digit  (digit),
    .pop    (pop),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

endmodule

/* src/itfmt_checker.sv */
// Port-level checker for the formatter, bound to the top level.
`include "integer_to_ascii_formatter_assert.svh"

module itfmt_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 strobe,
  input itfmt_pkg::out_item_t result
);

  // characters only come out of a number in progress
  `ITFMT_ASSERT_SAME(a_strobe_in_job, clk, rst, strobe, $past(busy), "beat without a job")

  // an accepted number goes busy and shows no beat in the next cycle
  `ITFMT_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy && !strobe, "bad accept")

  // the final character frees the block
  `ITFMT_ASSERT_SAME(a_last_frees, clk, rst, strobe && result.last_char, !busy,
    "busy after last beat")

  // busy only drops together with the final character
  `ITFMT_ASSERT_SAME(a_fall_on_last, clk, rst, !$past(rst) && $fell(busy),
    strobe && result.last_char, "busy dropped without last beat")

endmodule

bind integer_to_ascii_formatter itfmt_checker u_itfmt_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .strobe (strobe),
  .result (result)
);
